FILE: hw/rtl/sp_pifo_rank_queue_assert.svh
// ----------------------------------------------------------------------------
// SP-PIFO rank queue assertion macros
// Shared assertion forms for the checker of the rank queue.
// ----------------------------------------------------------------------------
`ifndef SP_PIFO_RANK_QUEUE_ASSERT_SVH
`define SP_PIFO_RANK_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SPPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication that is checked during reset as well.
`define SPPQ_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sppq_pkg.sv
// ----------------------------------------------------------------------------
// SP-PIFO rank queue package
// Sizes, codes and shared types of the strict-priority rank queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sppq_pkg;

  // Number of strict-priority FIFOs and the entries each one can hold.
  localparam int NUM_FIFOS  = 8;
  localparam int FIFO_DEPTH = 64;

  // Derived widths.
  localparam int IDX_W   = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
  localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_FIFOS * FIFO_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // Field widths of the channels.
  localparam int RANK_W  = 16;
  localparam int TAG_W   = 16;
  localparam int QOUT_W  = 3;

  // Configuration register.
  localparam int LIMIT_W = 7;
  localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [LIMIT_W-1:0] FIFO_LIMIT_RESET = 7'd60;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FIFO_LIMIT = 1'b0;

  // Commands.
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DROP  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Decision made by the scheduler for the item in the input register.
  typedef struct packed {
    status_t status;
    idx_t    queue;
    logic    store_wr;
    logic    store_rd;
    addr_t   store_addr;
  } sppq_dec_t;

  // Next position of a circular pointer.
  function automatic ptr_t wrap_ptr(input ptr_t p);
    logic [PTR_W:0] inc;
    inc = {1'b0, p} + 1'b1;
    if (inc >= (PTR_W+1)'(FIFO_DEPTH)) begin
      wrap_ptr = '0;
    end else begin
      wrap_ptr = inc[PTR_W-1:0];
    end
  endfunction

  // Flat store address of an entry of one FIFO.
  function automatic addr_t store_addr(input idx_t q, input ptr_t p);
    store_addr = ADDR_W'(q) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sppq_if.sv
// ----------------------------------------------------------------------------
// SP-PIFO rank queue channels
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sppq_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] rank;
  logic [15:0] packet_tag;

  modport source (output valid, output cmd, output rank, output packet_tag, input ready);
  modport sink   (input valid, input cmd, input rank, input packet_tag, output ready);
endinterface

interface sppq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  queue_index;
  logic [15:0] tag_out;

  modport source (output valid, output status, output queue_index, output tag_out,
                  input ready);
  modport sink   (input valid, input status, input queue_index, input tag_out,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sppq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sppq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sppq_sched.sv
// ----------------------------------------------------------------------------
// SP-PIFO scheduler
// Rank bounds, FIFO occupancy and pointers, and the per-item decision.
// ----------------------------------------------------------------------------
`default_nettype none

module sppq_sched (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic                        cmd,
  input  wire sppq_pkg::rank_t             rank,
  input  wire logic [sppq_pkg::LIMIT_W-1:0] fifo_limit,
  output sppq_pkg::sppq_dec_t              dec
);

  sppq_pkg::rank_t bounds [sppq_pkg::NUM_FIFOS];
  sppq_pkg::cnt_t  counts [sppq_pkg::NUM_FIFOS];
  sppq_pkg::ptr_t  heads  [sppq_pkg::NUM_FIFOS];
  sppq_pkg::ptr_t  tails  [sppq_pkg::NUM_FIFOS];

  sppq_pkg::idx_t  tgt;
  sppq_pkg::idx_t  deq_idx;
  sppq_pkg::idx_t  sel;
  logic            push_up;
  logic            deq_found;
  logic            full;
  logic            enq_ok;
  logic            deq_ok;
  sppq_pkg::ptr_t  sel_ptr;
  sppq_pkg::rank_t cost;
  logic [sppq_pkg::LIM_W-1:0] lim_eff;
  sppq_pkg::rank_t bounds_down [sppq_pkg::NUM_FIFOS];

  // Effective limit: anything above the FIFO depth acts as the depth.
  always_comb begin
    if (sppq_pkg::LIM_W'(fifo_limit) > sppq_pkg::LIM_W'(sppq_pkg::FIFO_DEPTH)) begin
      lim_eff = sppq_pkg::LIM_W'(sppq_pkg::FIFO_DEPTH);
    end else begin
      lim_eff = sppq_pkg::LIM_W'(fifo_limit);
    end
  end

  // Enqueue target: the highest-numbered FIFO whose bound is at or below the rank.
  always_comb begin
    tgt     = '0;
    push_up = 1'b0;
    for (int i = 0; i < sppq_pkg::NUM_FIFOS; i++) begin
      if (rank >= bounds[i]) begin
        tgt     = sppq_pkg::IDX_W'(i);
        push_up = 1'b1;
      end
    end
  end

  // Dequeue source: the lowest-numbered FIFO that holds a packet.
  always_comb begin
    deq_idx   = '0;
    deq_found = 1'b0;
    for (int i = sppq_pkg::NUM_FIFOS - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        deq_idx   = sppq_pkg::IDX_W'(i);
        deq_found = 1'b1;
      end
    end
  end

  // Push-down: every bound drops by the amount the rank undercuts bound zero.
  always_comb begin
    cost = bounds[0] - rank;
    for (int i = 0; i < sppq_pkg::NUM_FIFOS; i++) begin
      bounds_down[i] = (bounds[i] > cost) ? bounds[i] - cost : '0;
    end
  end

  // Decision for the item in the input register.
  always_comb begin
    sel     = (cmd == sppq_pkg::CMD_DEQ) ? deq_idx : tgt;
    full    = sppq_pkg::LIM_W'(counts[sel]) >= lim_eff;
    enq_ok  = (cmd == sppq_pkg::CMD_ENQ) && !full;
    deq_ok  = (cmd == sppq_pkg::CMD_DEQ) && deq_found;
    sel_ptr = (cmd == sppq_pkg::CMD_DEQ) ? heads[sel] : tails[sel];

    dec.queue      = sel;
    dec.store_wr   = enq_ok;
    dec.store_rd   = deq_ok;
    dec.store_addr = sppq_pkg::store_addr(sel, sel_ptr);
    if (cmd == sppq_pkg::CMD_ENQ) begin
      dec.status = full ? sppq_pkg::ST_DROP : sppq_pkg::ST_ENQ;
    end else begin
      dec.status = deq_found ? sppq_pkg::ST_DEQ : sppq_pkg::ST_EMPTY;
    end
  end

  // State update when the item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sppq_pkg::NUM_FIFOS; i++) begin
        bounds[i] <= '0;
        counts[i] <= '0;
        heads[i]  <= '0;
        tails[i]  <= '0;
      end
    end else if (fire) begin
      if (enq_ok) begin
        tails[sel]  <= sppq_pkg::wrap_ptr(tails[sel]);
        counts[sel] <= counts[sel] + 1'b1;
        if (!push_up) begin
          for (int i = 1; i < sppq_pkg::NUM_FIFOS; i++) begin
            bounds[i] <= bounds_down[i];
          end
        end
        bounds[sel] <= rank;
      end
      if (deq_ok) begin
        heads[sel]  <= sppq_pkg::wrap_ptr(heads[sel]);
        counts[sel] <= counts[sel] - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sp_pifo_rank_queue.sv
// ----------------------------------------------------------------------------
// SP-PIFO rank queue
// Strict-priority FIFOs with adaptive rank bounds approximating a PIFO.
// ----------------------------------------------------------------------------
// The block takes one enqueue or dequeue command in every cycle while the
// result side is not stalled, and returns exactly one result for each, in
// order. The command first lands in an input register; the scheduler then
// compares the rank against all bounds in parallel and updates bounds, counts
// and pointers in that same cycle; the result is registered together with the
// read data of the packet store, a single memory with one write and one read
// port. Throughput is set by that one pass, so it stays at one item per cycle
// unless stalled. The store needs no clearing after reset. fifo_limit must be
// written through the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module sp_pifo_rank_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sppq_req_if.sink                          req,
  sppq_rsp_if.source                        rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sppq_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sppq_pkg::PDATA_W-1:0] pwdata,
  output logic      [sppq_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  logic [sppq_pkg::LIMIT_W-1:0] fifo_limit;
  logic                         reg_idx;

  logic                         s1_valid;
  logic                         s1_cmd;
  sppq_pkg::rank_t              s1_rank;
  logic [sppq_pkg::TAG_W-1:0]   s1_tag;
  logic                         s1_fire;

  logic                         s2_valid;
  sppq_pkg::status_t            s2_status;
  sppq_pkg::idx_t               s2_queue;
  logic                         s2_free;

  sppq_pkg::sppq_dec_t          dec;
  logic [sppq_pkg::TAG_W-1:0]   rd_data;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[sppq_pkg::PADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_limit <= sppq_pkg::FIFO_LIMIT_RESET;
    end else if (psel && penable && pwrite && (reg_idx == sppq_pkg::REG_FIFO_LIMIT)) begin
      fifo_limit <= pwdata[sppq_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == sppq_pkg::REG_FIFO_LIMIT) begin
      prdata = sppq_pkg::PDATA_W'(fifo_limit);
    end
  end

  // Flow control between the input register and the result register.
  assign s2_free   = !s2_valid || rsp.ready;
  assign s1_fire   = s1_valid && s2_free;
  assign req.ready = !s1_valid || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_cmd  <= req.cmd;
      s1_rank <= req.rank;
      s1_tag  <= req.packet_tag;
    end
  end

  // Scheduler decision and state.
  sppq_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .cmd        (s1_cmd),
    .rank       (s1_rank),
    .fifo_limit (fifo_limit),
    .dec        (dec)
  );

  // Packet store.
  sppq_ram #(
    .WIDTH (sppq_pkg::TAG_W),
    .DEPTH (sppq_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (s1_fire && dec.store_wr),
    .wr_addr (dec.store_addr),
    .wr_data (s1_tag),
    .rd_en   (s1_fire && dec.store_rd),
    .rd_addr (dec.store_addr),
    .rd_data (rd_data)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_status <= dec.status;
      s2_queue  <= dec.queue;
    end
  end

  assign rsp.valid       = s2_valid;
  assign rsp.status      = s2_status;
  assign rsp.queue_index = sppq_pkg::QOUT_W'(s2_queue);
  assign rsp.tag_out     = (s2_status == sppq_pkg::ST_DEQ) ? rd_data : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/sppq_checker.sv
// ----------------------------------------------------------------------------
// SP-PIFO rank queue checker
// Port-level assertions on the results of the rank queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sp_pifo_rank_queue_assert.svh"

module sppq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [2:0]  rsp_queue_index,
  input wire logic [15:0] rsp_tag_out
);

  // An empty answer names queue zero and carries no tag.
  `SPPQ_ASSERT_IMPLY(a_empty_fields, clk, rst, rsp_valid && (rsp_status == sppq_pkg::ST_EMPTY), (rsp_queue_index == 3'd0) && (rsp_tag_out == 16'd0))

  // Only a dequeue carries a tag.
  `SPPQ_ASSERT_IMPLY(a_tag_only_on_deq, clk, rst, rsp_valid && (rsp_status != sppq_pkg::ST_DEQ), rsp_tag_out == 16'd0)

  // A stalled result holds its fields.
  `SPPQ_ASSERT_NEXT(a_stall_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_queue_index) && $stable(rsp_tag_out))

  // No result is shown in the cycle after reset.
  `SPPQ_ASSERT_ALWAYS(a_quiet_after_reset, clk, $past(rst), !rsp_valid)

endmodule

bind sp_pifo_rank_queue sppq_checker u_sppq_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_queue_index (rsp.queue_index),
  .rsp_tag_out     (rsp.tag_out)
);

`default_nettype wire

FILE: sim/tb_sp_pifo_rank_queue.sv
// ----------------------------------------------------------------------------
// Rank queue scheduler testbench
// Drives enqueue and dequeue commands into the strict-priority rank queue
// through its valid/ready channels, sets fifo_limit over the APB port, and
// checks every result against a cycle-free scheduler model in the bench or,
// for typed rows, the short directed table run first; then random traffic
// over several limits, random gaps, a long result-side stall and drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sp_pifo_rank_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import sppq_pkg::*;

  typedef logic [TAG_W-1:0] tag_t;

  // One scheduler decision as seen on the result channel.
  typedef struct packed {
    status_t             status;
    logic [QOUT_W-1:0]   queue;
    tag_t                tag;
  } sched_result_t;

  // One row of the directed table; the result is only used when typed is set.
  typedef struct packed {
    cmd_t          cmd;
    rank_t         rank;
    tag_t          tag;
    logic          typed;
    sched_result_t res;
  } dir_row_t;

  localparam sched_result_t UNCHECKED = '{status: ST_ENQ, queue: '0, tag: '0};
  localparam logic [PADDR_W-1:0] LIMIT_ADDR  = PADDR_W'(4 * int'(REG_FIFO_LIMIT));
  // An address with no register behind it; writes there must be ignored.
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(4);
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_PAD    = 6;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_DIR_ROWS = 24;

  // Directed table: reset behavior, field extremes, both commands, priority
  // order on dequeue, descending ranks that walk down the FIFOs and two
  // push-down enqueues.
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    '{CMD_DEQ, 16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 3'd0, 16'h0000}},
    '{CMD_ENQ, 16'h0000, 16'hFFFF, 1'b1, '{ST_ENQ,   3'd7, 16'h0000}},
    '{CMD_ENQ, 16'hFFFF, 16'h0000, 1'b1, '{ST_ENQ,   3'd7, 16'h0000}},
    '{CMD_ENQ, 16'h1234, 16'hA5A5, 1'b1, '{ST_ENQ,   3'd6, 16'h0000}},
    '{CMD_DEQ, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_DEQ,   3'd6, 16'hA5A5}},
    '{CMD_DEQ, 16'h0000, 16'h0000, 1'b1, '{ST_DEQ,   3'd7, 16'hFFFF}},
    '{CMD_DEQ, 16'h8000, 16'h8000, 1'b1, '{ST_DEQ,   3'd7, 16'h0000}},
    '{CMD_DEQ, 16'h0001, 16'h0001, 1'b1, '{ST_EMPTY, 3'd0, 16'h0000}},
    '{CMD_ENQ, 16'h9000, 16'h1111, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h8000, 16'h2222, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h7000, 16'h3333, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h6000, 16'h4444, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h5000, 16'h5555, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h4000, 16'h6666, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h3000, 16'h7777, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h0010, 16'h8888, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h0FFF, 16'h9999, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'h0000, 16'hAAAA, 1'b0, UNCHECKED},
    '{CMD_ENQ, 16'hFFFF, 16'hBBBB, 1'b0, UNCHECKED},
    '{CMD_DEQ, 16'h5A5A, 16'h5A5A, 1'b0, UNCHECKED},
    '{CMD_DEQ, 16'hA5A5, 16'hA5A5, 1'b0, UNCHECKED},
    '{CMD_DEQ, 16'h0000, 16'h0000, 1'b0, UNCHECKED},
    '{CMD_DEQ, 16'hFFFF, 16'hFFFF, 1'b0, UNCHECKED},
    '{CMD_DEQ, 16'h0000, 16'h0000, 1'b0, UNCHECKED}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  sppq_req_if req_ch ();
  sppq_rsp_if rsp_ch ();

  sp_pifo_rank_queue u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scheduler model state.
  logic [LIMIT_W-1:0] limit_reg;
  rank_t              bound_q   [NUM_FIFOS];
  int                 fill      [NUM_FIFOS];
  ptr_t               rd_ptr    [NUM_FIFOS];
  ptr_t               wr_ptr    [NUM_FIFOS];
  tag_t               pkt_store [NUM_FIFOS][FIFO_DEPTH];

  sched_result_t pending_results[$];
  int    error_count;
  int    cmds_sent;
  int    limit_settings;
  int    n_enq;
  int    n_drop;
  int    n_deq;
  int    n_empty;
  int    cycle_count;
  bit    req_idle;
  bit    rsp_idle;
  bit    hold_request;
  rank_t sweep_rank;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
             cycle_count, pending_results.size());
    $display("sp_pifo_rank_queue test failed");
    $finish;
  end

  // Next slot of a circular FIFO pointer.
  function automatic ptr_t next_slot(input ptr_t p);
    return (int'(p) == FIFO_DEPTH - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  // Apply one command to the scheduler model and return the result it gives.
  function automatic sched_result_t schedule_item(input cmd_t cmd, input rank_t rank,
                                                  input tag_t tag);
    sched_result_t res;
    int            target;
    int            cap;
    bit            found;
    rank_t         cost;
    res    = '{status: ST_EMPTY, queue: '0, tag: '0};
    cap    = (int'(limit_reg) > FIFO_DEPTH) ? FIFO_DEPTH : int'(limit_reg);
    target = 0;
    found  = 1'b0;
    if (cmd == CMD_ENQ) begin
      // Push-up: the highest-numbered FIFO whose bound does not exceed the rank.
      for (int i = NUM_FIFOS - 1; i >= 0; i--) begin
        if (!found && rank >= bound_q[i]) begin
          target = i;
          found  = 1'b1;
        end
      end
      res.queue = QOUT_W'(target);
      if (fill[target] >= cap) begin
        res.status = ST_DROP;
      end else begin
        pkt_store[target][wr_ptr[target]] = tag;
        wr_ptr[target] = next_slot(wr_ptr[target]);
        fill[target]++;
        // Push-down: every other bound drops by the overshoot, floored at zero.
        if (!found) begin
          cost = bound_q[0] - rank;
          for (int i = 1; i < NUM_FIFOS; i++) begin
            bound_q[i] = (bound_q[i] > cost) ? rank_t'(bound_q[i] - cost) : '0;
          end
        end
        bound_q[target] = rank;
        res.status = ST_ENQ;
      end
    end else begin
      // Strict priority: the lowest-numbered FIFO that holds a packet.
      for (int i = 0; i < NUM_FIFOS; i++) begin
        if (!found && fill[i] > 0) begin
          found      = 1'b1;
          res.status = ST_DEQ;
          res.queue  = QOUT_W'(i);
          res.tag    = pkt_store[i][rd_ptr[i]];
          rd_ptr[i]  = next_slot(rd_ptr[i]);
          fill[i]--;
        end
      end
    end
    return res;
  endfunction

  // Offer one command after a random gap and record its result on transfer.
  task automatic send_item(input cmd_t cmd, input rank_t rank, input tag_t tag,
                           input logic typed, input sched_result_t typed_res);
    int            gap;
    sched_result_t res;
    gap = req_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.rank       <= rank;
    req_ch.packet_tag <= tag;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    res = schedule_item(cmd, rank, tag);
    pending_results.push_back(typed ? typed_res : res);
    cmds_sent++;
  endtask

  // Stop offering and wait until every result has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // One APB transfer; returns the read data sampled at the access edge.
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register while the block is idle, then read fifo_limit back.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [LIMIT_W-1:0] value);
    logic [PDATA_W-1:0] rdata;
    wait_drained();
    apb_access(1'b1, addr, PDATA_W'(value), rdata);
    if (addr == LIMIT_ADDR) begin
      limit_reg = value;
      limit_settings++;
    end
    apb_access(1'b0, LIMIT_ADDR, '0, rdata);
    if (rdata !== PDATA_W'(limit_reg)) begin
      error_count++;
      $display("%0t: fifo_limit readback mismatch: expected %0d, got %0d", $time,
               limit_reg, rdata);
    end
  endtask

  // Random traffic: enq_pct percent enqueues, structured ranks, rest dequeues.
  task automatic run_random(input int count, input int enq_pct);
    cmd_t  cmd;
    rank_t rank;
    for (int k = 0; k < count; k++) begin
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      case ($urandom_range(0, 3))
        0: rank = rank_t'($urandom_range(0, 65535));
        1: begin
          // Descending runs keep the bounds adapting and trigger push-downs.
          sweep_rank = sweep_rank - rank_t'($urandom_range(0, 3000));
          rank = sweep_rank;
        end
        2: rank = sweep_rank + rank_t'($urandom_range(0, 255));
        default: begin
          case ($urandom_range(0, 3))
            0:       rank = 16'h0000;
            1:       rank = 16'h0001;
            2:       rank = 16'hFFFE;
            default: rank = 16'hFFFF;
          endcase
        end
      endcase
      send_item(cmd, rank, tag_t'($urandom_range(0, 65535)), 1'b0, UNCHECKED);
      if ($urandom_range(0, 149) == 0) begin
        wait_drained();
      end
    end
  endtask

  // Result side: random stalls, one long hold on request, and the checks.
  initial begin : result_check
    sched_result_t want;
    sched_result_t got;
    int            stall;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = rsp_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
      got = '{status: status_t'(rsp_ch.status), queue: rsp_ch.queue_index,
              tag: rsp_ch.tag_out};
      case (got.status)
        ST_ENQ:   n_enq++;
        ST_DROP:  n_drop++;
        ST_DEQ:   n_deq++;
        default:  n_empty++;
      endcase
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: status=%0d queue=%0d tag=%h",
                 $time, rsp_ch.status, got.queue, got.tag);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.queue !== want.queue ||
            got.tag !== want.tag) begin
          error_count++;
          $display("%0t: mismatch: expected status=%s queue=%0d tag=%h, got status=%0d queue=%0d tag=%h",
                   $time, want.status.name(), want.queue, want.tag,
                   rsp_ch.status, got.queue, got.tag);
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases over several limits.
  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_ENQ;
    req_ch.rank       <= '0;
    req_ch.packet_tag <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    error_count    = 0;
    cmds_sent      = 0;
    limit_settings = 1;
    n_enq          = 0;
    n_drop         = 0;
    n_deq          = 0;
    n_empty        = 0;
    req_idle       = 1'b1;
    rsp_idle       = 1'b1;
    hold_request   = 1'b0;
    sweep_rank     = 16'hC000;
    limit_reg      = FIFO_LIMIT_RESET;
    for (int i = 0; i < NUM_FIFOS; i++) begin
      bound_q[i] = '0;
      fill[i]    = 0;
      rd_ptr[i]  = '0;
      wr_ptr[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      send_item(DIR_ROWS[r].cmd, DIR_ROWS[r].rank, DIR_ROWS[r].tag, DIR_ROWS[r].typed,
                DIR_ROWS[r].res);
    end
    wait_drained();

    // Reset limit first, then one packet per FIFO and a limit of zero.
    run_random(300, 60);
    write_reg(LIMIT_ADDR, 7'd1);
    run_random(250, 60);
    write_reg(LIMIT_ADDR, 7'd0);
    run_random(60, 50);

    // Largest limit, no idling, and a long result stall that backs up the input.
    write_reg(LIMIT_ADDR, 7'h7F);
    req_idle     = 1'b0;
    rsp_idle     = 1'b0;
    hold_request = 1'b1;
    run_random(500, 90);
    req_idle = 1'b1;
    rsp_idle = 1'b1;

    // A write to an unused address must leave fifo_limit alone.
    write_reg(UNUSED_ADDR, 7'd5);
    run_random(100, 50);
    write_reg(LIMIT_ADDR, 7'(FIFO_DEPTH));
    run_random(300, 35);
    write_reg(LIMIT_ADDR, 7'($urandom_range(2, 63)));
    run_random(300, 60);
    write_reg(LIMIT_ADDR, FIFO_LIMIT_RESET);
    run_random(200, 55);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d commands under %0d fifo_limit settings, zero and above depth included.",
             cmds_sent, limit_settings);
    $display("Results seen: %0d enqueued, %0d dropped, %0d dequeued, %0d empty; %0d errors.",
             n_enq, n_drop, n_deq, n_empty, error_count);
    if (error_count == 0) begin
      $display("sp_pifo_rank_queue test passed");
    end else begin
      $display("sp_pifo_rank_queue test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sppq_pkg.sv
hw/rtl/sppq_if.sv
hw/rtl/sppq_ram.sv
hw/rtl/sppq_sched.sv
hw/rtl/sp_pifo_rank_queue.sv
hw/rtl/sppq_checker.sv
sim/tb_sp_pifo_rank_queue.sv
